@@ src/rdc_pkg.sv @@
// shared types, constants, the digit glyph function and the radix clamp function of the radix digit converter
package rdc_pkg;

  localparam int VALUE_PORT_W = 64;
  localparam int RADIX_W = 6;
  localparam int CHAR_W = 7;

  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [CHAR_W-1:0] char_t;

  localparam radix_t RADIX_MIN = 6'd2;
  localparam radix_t RADIX_MAX = 6'd36;
  localparam radix_t RADIX_RESET = 6'd10;
  localparam radix_t DEC_LIMIT = 6'd10;
  localparam char_t CHAR_ZERO = 7'h30;
  localparam char_t CHAR_A = 7'h41;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT,
    B_READ
  } back_state_t;

  // remainder to ascii digit
  function automatic char_t glyph(input radix_t r);
    char_t c;
    if (r < DEC_LIMIT) begin
      c = CHAR_ZERO + {1'b0, r};
    end else begin
      c = CHAR_A + {1'b0, r - DEC_LIMIT};
    end
    return c;
  endfunction

  // limit a written radix to the legal range
  function automatic radix_t clamp_radix(input radix_t r);
    radix_t c;
    if (r < RADIX_MIN) begin
      c = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      c = RADIX_MAX;
    end else begin
      c = r;
    end
    return c;
  endfunction

endpackage

@@ src/rdc_front.sv @@
// input side: two-entry queue of values, each tagged with the radix in force
module rdc_front import rdc_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] value_in,
  input  radix_t       radix_in,
  output logic         item_valid,
  output logic [W-1:0] item_value,
  output radix_t       item_radix,
  input  logic         item_take
);

  logic [W-1:0] val_q [2];
  radix_t       rad_q [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         wr_en;
  logic         rd_en;

  assign full = (count == 2'd2);
  assign wr_en = push && !full;
  assign rd_en = item_take && item_valid;
  assign item_valid = (count != 2'd0);
  assign item_value = val_q[rd_ptr];
  assign item_radix = rad_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_q[wr_ptr] <= value_in;
      rad_q[wr_ptr] <= radix_in;
    end
  end

endmodule

@@ src/rdc_div.sv @@
// bit-serial restoring divider by a small radix, one quotient bit per cycle
module rdc_div import rdc_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  radix_t       divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output radix_t       rem
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  radix_t           dvs;
  logic [RADIX_W:0] trial;
  logic [RADIX_W:0] diff;
  logic             ge;

  assign trial = {rem, quot[W-1]};
  assign diff = trial - {1'b0, dvs};
  assign ge = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quot <= {quot[W-2:0], ge};
      rem <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    end
  end

endmodule

@@ src/rdc_back.sv @@
// back end: repeated division into a digit stack, then digits out most significant first
module rdc_back import rdc_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic [W-1:0] item_value,
  input  radix_t       item_radix,
  output logic         item_take,
  output logic         empty,
  input  logic         pop,
  output char_t       digit_char,
  output logic         last_digit
);

  localparam int NW = $clog2(W + 1);
  localparam int IW = $clog2(W);

  back_state_t  state;
  back_state_t  state_next;
  radix_t       cur_radix;
  logic [NW-1:0] n;
  logic [IW-1:0] k;
  radix_t       mem [W];
  radix_t       rd_data;
  logic         out_valid;

  logic         div_start;
  logic [W-1:0] div_dividend;
  radix_t       div_divisor;
  logic         div_done;
  logic [W-1:0] div_quot;
  radix_t       div_rem;
  logic         dig_wr;
  logic         rd_en;
  logic         out_load;

  rdc_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_take = 1'b0;
    div_start = 1'b0;
    div_dividend = div_quot;
    div_divisor = cur_radix;
    dig_wr = 1'b0;
    rd_en = 1'b0;
    out_load = 1'b0;
    case (state)
      B_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          div_start = 1'b1;
          div_dividend = item_value;
          div_divisor = item_radix;
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (div_done) begin
          dig_wr = 1'b1;
          if (div_quot == '0) begin
            state_next = B_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      B_EMIT: begin
        if (!out_valid) begin
          rd_en = 1'b1;
          state_next = B_READ;
        end
      end
      B_READ: begin
        out_load = 1'b1;
        state_next = (k == '0) ? B_IDLE : B_EMIT;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      cur_radix <= item_radix;
      n <= '0;
    end else if (dig_wr) begin
      n <= n + NW'(1);
      // the stack top becomes the first digit to send
      k <= n[IW-1:0];
    end else if (out_load) begin
      k <= k - IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dig_wr) begin
      mem[n[IW-1:0]] <= div_rem;
    end
    if (rd_en) begin
      rd_data <= mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digit_char <= glyph(rd_data);
      last_digit <= (k == '0);
    end
  end

  assign empty = !out_valid;

endmodule

@@ src/radix_digit_converter.sv @@
// top level of the radix digit converter: radix register, input queue and conversion engine
//
// usage:
//   input: push a 64-bit value while full is low; only the low VALUE_WIDTH bits count.
//   results: while empty is low, digit_char holds an ascii digit ('0'-'9', 'A'-'Z')
//   and last_digit marks the least significant digit; pop takes it. digits come
//   most significant first, zero gives a single '0', no leading zeros.
//   config: cfg_valid/cfg_ready write radix (2..36, out-of-range writes clamp);
//   cfg_ready is always high. write it only while the block is idle.
// timing:
//   each digit costs one bit-serial division, the next division starting on the cycle the
//   last one finishes. after the last division each digit is read from the stack in
//   B_EMIT into a register and loaded into the output register in B_READ; a new value
//   is taken only once the least significant digit of the last one is loaded.
// reset: radix returns to 10, the input queue and output register empty.
// stall: the output register holds its digit until popped; the engine waits,
//   the two-entry input queue keeps accepting until full.
module radix_digit_converter import rdc_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [VALUE_PORT_W-1:0] value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  radix_t                  radix,
  output logic                    empty,
  input  logic                    pop,
  output char_t                   digit_char,
  output logic                    last_digit
);

  radix_t                 radix_reg;
  logic                   item_valid;
  logic [VALUE_WIDTH-1:0] item_value;
  radix_t                 item_radix;
  logic                   item_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_reg <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix_reg <= clamp_radix(radix);
    end
  end

  rdc_front #(.W(VALUE_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .value_in   (value[VALUE_WIDTH-1:0]),
    .radix_in   (radix_reg),
    .item_valid (item_valid),
    .item_value (item_value),
    .item_radix (item_radix),
    .item_take  (item_take)
  );

  rdc_back #(.W(VALUE_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_value (item_value),
    .item_radix (item_radix),
    .item_take  (item_take),
    .empty      (empty),
    .pop        (pop),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

endmodule
